// ===== sv/ile_pkg.sv =====
// ile_pkg: shared types and codes for the indexed list engine.
// No dependencies; used by ile_cell and indexed_list_engine.
package ile_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 16;  // cell index width, covers the largest capacity

  typedef enum logic [2:0] {
    REQ_APPEND  = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_REMOVE  = 3'd2,
    REQ_REPLACE = 3'd3,
    REQ_READ    = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_RD_LOAD,
    CELL_RD_FOLD
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                  cmd;
    logic [POS_W-1:0]           pos;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_FOLD,
    FSM_OUT
  } fsm_t;

endpackage

// ===== sv/ile_cell.sv =====
// ile_cell: one list entry plus one stage of the read-out chain.
// Depends on ile_pkg.
module ile_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  ile_pkg::cell_ctrl_t                ctrl,
  input  logic signed [ile_pkg::VALUE_W-1:0] prev_data,
  input  logic signed [ile_pkg::VALUE_W-1:0] next_data,
  input  logic signed [ile_pkg::VALUE_W-1:0] prev_rd,
  output logic signed [ile_pkg::VALUE_W-1:0] data,
  output logic signed [ile_pkg::VALUE_W-1:0] rd
);

  localparam logic [ile_pkg::POS_W-1:0] IDX_V = ile_pkg::POS_W'(IDX);

  logic hit;
  logic above;

  assign hit   = (ctrl.pos == IDX_V);
  assign above = (IDX_V > ctrl.pos);

  // entry storage: no reset, only entries below the count are ever read
  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      ile_pkg::CELL_WRITE: begin
        if (hit) data <= ctrl.value;
      end
      ile_pkg::CELL_SHIFT_UP: begin
        if (hit) data <= ctrl.value;
        else if (above) data <= prev_data;
      end
      ile_pkg::CELL_SHIFT_DOWN: begin
        if (hit || above) data <= next_data;
      end
      default: begin
      end
    endcase
  end

  // read chain: load the addressed entry, then OR toward the last cell
  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      ile_pkg::CELL_RD_LOAD: begin
        rd <= hit ? data : '0;
      end
      ile_pkg::CELL_RD_FOLD: begin
        rd <= rd | prev_rd;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/indexed_list_engine.sv =====
// indexed_list_engine: ordered list of signed 32-bit values held in a row of cells.
// Depends on ile_pkg and ile_cell.
//
// Usage:
//  - Request channel: req_type, position, value are taken at a rising edge with
//    start high and busy low. Codes: append, insert, remove, replace, read;
//    other codes only report the count.
//  - Result channel: done is high for exactly one cycle with read_value, status
//    and count. The receiver cannot stall; each result must be taken when shown.
//  - Append, insert, remove and replace write the addressed cell or shift the
//    cells at and above the position in parallel. Their result appears the cycle
//    after acceptance and busy stays low, so one such request can be accepted every cycle.
//  - A read with a good index loads the addressed entry into the read chain,
//    then folds it one cell per cycle toward the last cell, then takes the last
//    cell's value as the result. Busy is high through the fold and output states,
//    so no new request is taken until the read's result is registered.
//  - A bad index changes nothing and reports status 1 (read_value -1 for a
//    read); a full list rejects append and a good-index insert with status 2.
//  - Reset (rst, synchronous) empties the list and clears the control state;
//    entry contents are not cleared and are never read before being written.
module indexed_list_engine #(
  parameter int CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          req_type,
  input  logic [8:0]          position,
  input  logic signed [31:0]  value,
  output logic                done,
  output logic signed [31:0]  read_value,
  output logic [1:0]          status,
  output logic [8:0]          count
);

  localparam int CW   = $clog2(CAPACITY + 1);   // element count width
  localparam int CMPW = (CW > 9) ? CW : 9;      // width for index checks
  localparam int IW   = $clog2(CAPACITY);       // fold counter width

  localparam logic [CW-1:0] CAP_V     = CW'(CAPACITY);
  localparam logic [IW-1:0] FOLD_LAST = IW'(CAPACITY - 2);

  ile_pkg::fsm_t       state, state_next;
  ile_pkg::cell_ctrl_t ctrl;

  logic [CW-1:0] elem_count, elem_count_next;
  logic [IW-1:0] fold_cnt, fold_cnt_next;

  logic                               done_next;
  logic signed [ile_pkg::VALUE_W-1:0] read_value_reg, read_value_next;
  ile_pkg::status_t                   status_reg, status_next;

  logic signed [ile_pkg::VALUE_W-1:0] cell_data [CAPACITY];
  logic signed [ile_pkg::VALUE_W-1:0] cell_rd   [CAPACITY];

  logic            accept;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic            full;
  ile_pkg::req_t   req;

  assign accept = start && !busy;
  assign pos_x  = CMPW'(position);
  assign cnt_x  = CMPW'(elem_count);
  assign full   = (elem_count == CAP_V);
  assign req    = ile_pkg::req_t'(req_type);

  assign busy       = (state != ile_pkg::FSM_IDLE);
  assign read_value = read_value_reg;
  assign status     = status_reg;
  assign count      = 9'(elem_count);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ile_pkg::FSM_IDLE: begin
        if (accept && req == ile_pkg::REQ_READ && pos_x < cnt_x)
          state_next = ile_pkg::FSM_FOLD;
      end
      ile_pkg::FSM_FOLD: begin
        if (fold_cnt == '0) state_next = ile_pkg::FSM_OUT;
      end
      ile_pkg::FSM_OUT: begin
        state_next = ile_pkg::FSM_IDLE;
      end
      default: begin
        state_next = ile_pkg::FSM_IDLE;
      end
    endcase
  end

  // outputs: cell command, count update, result
  always_comb begin
    ctrl.cmd        = ile_pkg::CELL_HOLD;
    ctrl.pos        = ile_pkg::POS_W'(position);
    ctrl.value      = value;
    elem_count_next = elem_count;
    fold_cnt_next   = fold_cnt;
    done_next       = 1'b0;
    read_value_next = read_value_reg;
    status_next     = status_reg;
    case (state)
      ile_pkg::FSM_IDLE: begin
        if (accept) begin
          done_next       = 1'b1;
          read_value_next = '0;
          status_next     = ile_pkg::ST_DONE;
          case (req)
            ile_pkg::REQ_APPEND: begin
              if (full) begin
                status_next = ile_pkg::ST_FULL;
              end else begin
                ctrl.cmd        = ile_pkg::CELL_WRITE;
                ctrl.pos        = ile_pkg::POS_W'(elem_count);
                elem_count_next = elem_count + 1'b1;
              end
            end
            ile_pkg::REQ_INSERT: begin
              if (pos_x > cnt_x) begin
                status_next = ile_pkg::ST_RANGE;
              end else if (full) begin
                status_next = ile_pkg::ST_FULL;
              end else begin
                ctrl.cmd        = ile_pkg::CELL_SHIFT_UP;
                elem_count_next = elem_count + 1'b1;
              end
            end
            ile_pkg::REQ_REMOVE: begin
              if (pos_x >= cnt_x) begin
                status_next = ile_pkg::ST_RANGE;
              end else begin
                ctrl.cmd        = ile_pkg::CELL_SHIFT_DOWN;
                elem_count_next = elem_count - 1'b1;
              end
            end
            ile_pkg::REQ_REPLACE: begin
              if (pos_x >= cnt_x) status_next = ile_pkg::ST_RANGE;
              else ctrl.cmd = ile_pkg::CELL_WRITE;
            end
            ile_pkg::REQ_READ: begin
              if (pos_x >= cnt_x) begin
                status_next     = ile_pkg::ST_RANGE;
                read_value_next = '1;
              end else begin
                // good read: result comes after the fold
                done_next     = 1'b0;
                ctrl.cmd      = ile_pkg::CELL_RD_LOAD;
                fold_cnt_next = FOLD_LAST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ile_pkg::FSM_FOLD: begin
        ctrl.cmd      = ile_pkg::CELL_RD_FOLD;
        fold_cnt_next = fold_cnt - 1'b1;
      end
      ile_pkg::FSM_OUT: begin
        done_next       = 1'b1;
        read_value_next = cell_rd[CAPACITY-1];
        status_next     = ile_pkg::ST_DONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ile_pkg::FSM_IDLE;
      elem_count <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      elem_count <= elem_count_next;
      done       <= done_next;
    end
  end

  // result payload and fold counter need no reset
  always_ff @(posedge clk) begin
    read_value_reg <= read_value_next;
    status_reg     <= status_next;
    fold_cnt       <= fold_cnt_next;
  end

  // the row of cells; ends tie back to harmless values
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ile_pkg::VALUE_W-1:0] prev_data;
    logic signed [ile_pkg::VALUE_W-1:0] next_data;
    logic signed [ile_pkg::VALUE_W-1:0] prev_rd;

    if (i == 0) begin : g_first
      assign prev_data = value;
      assign prev_rd   = '0;
    end else begin : g_mid
      assign prev_data = cell_data[i-1];
      assign prev_rd   = cell_rd[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_inner
      assign next_data = cell_data[i+1];
    end

    ile_cell #(
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .prev_data (prev_data),
      .next_data (next_data),
      .prev_rd   (prev_rd),
      .data      (cell_data[i]),
      .rd        (cell_rd[i])
    );
  end

endmodule
